/* rtl/core/mftf_pkg.sv */
// Shared types and constants for the multi-frame texel fusion block.
// Used by multi_frame_texel_fusion and its testbench; depends on nothing.
package mftf_pkg;

  localparam int unsigned TEXEL_COUNT = 65536;
  localparam int unsigned ADDR_W      = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned STEP_W      = $clog2(SUM_W);
  localparam int unsigned ENTRY_W     = 3 * SUM_W + CNT_W;
  localparam int unsigned CMP_W       = CH_W + SUM_W;

  localparam logic [CH_W-1:0]  RATIO_RESET = CH_W'(5);
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ACT_DARK    = 3'd0,
    ACT_FIRST   = 3'd1,
    ACT_REJECT  = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_ADD     = 3'd4,
    ACT_READ    = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_ROUND,
    ST_CMP,
    ST_DECIDE,
    ST_DONE
  } state_e;

endpackage

/* rtl/core/multi_frame_texel_fusion.sv */
// Multi-frame texel fusion: per-texel RGB sums and counts, outlier test, rounded means.
// Depends on mftf_pkg and mftf_ram; one shared restoring divider serves all channels.
//
//   channel   | signals                                         | handshake
//   ----------+-------------------------------------------------+------------------------
//   request   | mode_i texel_index_i red_in_i green_in_i blue_in_i | start_i && !busy_o
//   result    | red_avg_o green_avg_o blue_avg_o sample_total_o action_o | done_o, one cycle
//   config    | cfg_wdata_i (outlier_ratio)                     | cfg_we_i
//
// After reset the store is swept to zero, one texel a cycle, with busy_o high throughout.
// A read, dark or first-sample beat runs one load state, then per channel 16 divider steps and
// a rounding state, then raises done_o. A fold that runs the outlier test adds a compare state
// after each channel mean; a decide state then writes the texel (unless it is rejected) and the
// three means are divided again for the result before done_o. done_o is high for exactly one
// cycle; the receiver cannot stall and busy_o stays high until that cycle ends, so the next
// beat is accepted only after the previous one has raised done_o.
module multi_frame_texel_fusion (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         mode_i,
  input  logic [mftf_pkg::IDX_W-1:0]   texel_index_i,
  input  logic [mftf_pkg::CH_W-1:0]    red_in_i,
  input  logic [mftf_pkg::CH_W-1:0]    green_in_i,
  input  logic [mftf_pkg::CH_W-1:0]    blue_in_i,
  input  logic                         cfg_we_i,
  input  logic [mftf_pkg::CH_W-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic [mftf_pkg::CH_W-1:0]    red_avg_o,
  output logic [mftf_pkg::CH_W-1:0]    green_avg_o,
  output logic [mftf_pkg::CH_W-1:0]    blue_avg_o,
  output logic [mftf_pkg::CNT_W-1:0]   sample_total_o,
  output logic [2:0]                   action_o
);

  localparam int unsigned SUM_W  = mftf_pkg::SUM_W;
  localparam int unsigned CNT_W  = mftf_pkg::CNT_W;
  localparam int unsigned CH_W   = mftf_pkg::CH_W;
  localparam int unsigned ADDR_W = mftf_pkg::ADDR_W;
  localparam int unsigned STEP_W = mftf_pkg::STEP_W;
  localparam int unsigned CMP_W  = mftf_pkg::CMP_W;
  localparam int unsigned EXT_W  = 25;

  mftf_pkg::state_e  state_q, state_d;
  mftf_pkg::action_e act_q, act_d;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CH_W-1:0]   ratio_q;
  logic [1:0]        chan_q, chan_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              check_q, check_d;
  logic              above_q, above_d;
  logic              below_q, below_d;

  logic              mode_q, mode_d;
  logic              ok_q, ok_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [CH_W-1:0]   smp_q [3];
  logic [CH_W-1:0]   smp_d [3];
  logic [SUM_W-1:0]  sum_q [3];
  logic [SUM_W-1:0]  sum_d [3];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  mean_q, mean_d;
  logic [CH_W-1:0]   out_q [3];
  logic [CH_W-1:0]   out_d [3];

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_addr;
  logic [mftf_pkg::ENTRY_W-1:0] ram_wdata;
  logic [mftf_pkg::ENTRY_W-1:0] ram_rdata;

  logic [EXT_W-1:0]  in_idx_ext;
  logic              in_ok;

  assign in_idx_ext = EXT_W'(texel_index_i);
  assign in_ok      = in_idx_ext < EXT_W'(mftf_pkg::TEXEL_COUNT);

  mftf_ram #(
    .WIDTH (mftf_pkg::ENTRY_W),
    .DEPTH (mftf_pkg::TEXEL_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mftf_pkg::ST_CLEAR;
      clr_q   <= '0;
      ratio_q <= mftf_pkg::RATIO_RESET;
      act_q   <= mftf_pkg::ACT_DARK;
      chan_q  <= '0;
      step_q  <= '0;
      check_q <= 1'b0;
      above_q <= 1'b0;
      below_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      act_q   <= act_d;
      chan_q  <= chan_d;
      step_q  <= step_d;
      check_q <= check_d;
      above_q <= above_d;
      below_q <= below_d;
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    ok_q   <= ok_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    mean_q <= mean_d;
    for (int c = 0; c < 3; c++) begin
      smp_q[c] <= smp_d[c];
      sum_q[c] <= sum_d[c];
      out_q[c] <= out_d[c];
    end
  end

  always_comb begin
    logic [CNT_W:0]    trial;
    logic              ge;
    logic [CNT_W:0]    two_r;
    logic              round_up;
    logic [SUM_W:0]    rounded;
    logic [SUM_W-1:0]  prod_a;
    logic [CMP_W-1:0]  prod_b;
    logic              any_dark;
    logic              advance;
    logic              start_div;
    logic [1:0]        chan_nx;
    logic [SUM_W:0]    acc;

    state_d   = state_q;
    clr_d     = clr_q;
    act_d     = act_q;
    chan_d    = chan_q;
    step_d    = step_q;
    check_d   = check_q;
    above_d   = above_q;
    below_d   = below_q;
    mode_d    = mode_q;
    ok_d      = ok_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    num_d     = num_q;
    rem_d     = rem_q;
    mean_d    = mean_q;
    smp_d     = smp_q;
    sum_d     = sum_q;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    advance   = 1'b0;
    start_div = 1'b0;
    chan_nx   = chan_q + 2'd1;

    trial    = {rem_q, num_q[SUM_W-1]};
    ge       = trial >= {1'b0, cnt_q};
    two_r    = {rem_q, 1'b0};
    round_up = (two_r > {1'b0, cnt_q}) || ((two_r == {1'b0, cnt_q}) && num_q[0]);
    rounded  = {1'b0, num_q} + (SUM_W + 1)'(round_up);
    prod_a   = SUM_W'(ratio_q) * SUM_W'(smp_q[chan_q]);
    prod_b   = CMP_W'(ratio_q) * CMP_W'(mean_q);
    any_dark = (smp_q[0] == '0) || (smp_q[1] == '0) || (smp_q[2] == '0);
    acc      = '0;

    case (state_q)
      mftf_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(mftf_pkg::TEXEL_COUNT - 1)) begin
          state_d = mftf_pkg::ST_IDLE;
        end
      end
      mftf_pkg::ST_IDLE: begin
        ram_addr = in_idx_ext[ADDR_W-1:0];
        if (start_i) begin
          mode_d   = mode_i;
          ok_d     = in_ok;
          idx_d    = in_idx_ext[ADDR_W-1:0];
          smp_d[0] = red_in_i;
          smp_d[1] = green_in_i;
          smp_d[2] = blue_in_i;
          state_d  = mftf_pkg::ST_LOAD;
        end
      end
      mftf_pkg::ST_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          sum_d[c] = ram_rdata[CNT_W + c * SUM_W +: SUM_W];
        end
        cnt_d   = ram_rdata[CNT_W-1:0];
        check_d = 1'b0;
        above_d = 1'b1;
        below_d = 1'b1;
        if (!ok_q) begin
          for (int c = 0; c < 3; c++) begin
            sum_d[c] = '0;
          end
          cnt_d = '0;
          act_d = mode_q ? mftf_pkg::ACT_READ : mftf_pkg::ACT_DARK;
        end else if (mode_q) begin
          act_d = mftf_pkg::ACT_READ;
        end else if (any_dark) begin
          act_d = mftf_pkg::ACT_DARK;
        end else if (ram_rdata[CNT_W-1:0] == '0) begin
          for (int c = 0; c < 3; c++) begin
            sum_d[c] = SUM_W'(smp_q[c]);
          end
          cnt_d  = CNT_W'(1);
          act_d  = mftf_pkg::ACT_FIRST;
          ram_we = 1'b1;
        end else begin
          check_d = 1'b1;
        end
        start_div = 1'b1;
      end
      mftf_pkg::ST_DIV: begin
        num_d = {num_q[SUM_W-2:0], ge};
        rem_d = ge ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = mftf_pkg::ST_ROUND;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      mftf_pkg::ST_ROUND: begin
        mean_d = (cnt_q == '0) ? '0 : rounded[SUM_W-1:0];
        if (cnt_q == '0) begin
          out_d[chan_q] = '0;
        end else if (rounded > (SUM_W + 1)'({CH_W{1'b1}})) begin
          out_d[chan_q] = {CH_W{1'b1}};
        end else begin
          out_d[chan_q] = rounded[CH_W-1:0];
        end
        if (check_q) begin
          state_d = mftf_pkg::ST_CMP;
        end else begin
          advance = 1'b1;
        end
      end
      mftf_pkg::ST_CMP: begin
        above_d = above_q && (mean_q > prod_a);
        below_d = below_q && (prod_b < CMP_W'(smp_q[chan_q]));
        advance = 1'b1;
      end
      mftf_pkg::ST_DECIDE: begin
        check_d = 1'b0;
        if (above_q) begin
          act_d = mftf_pkg::ACT_REJECT;
        end else if (below_q) begin
          for (int c = 0; c < 3; c++) begin
            sum_d[c] = SUM_W'(smp_q[c]);
          end
          cnt_d  = CNT_W'(1);
          act_d  = mftf_pkg::ACT_RESTART;
          ram_we = 1'b1;
        end else begin
          for (int c = 0; c < 3; c++) begin
            acc      = {1'b0, sum_q[c]} + (SUM_W + 1)'(smp_q[c]);
            sum_d[c] = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
          end
          if (cnt_q != mftf_pkg::CNT_MAX) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          act_d  = mftf_pkg::ACT_ADD;
          ram_we = 1'b1;
        end
        start_div = 1'b1;
      end
      mftf_pkg::ST_DONE: begin
        state_d = mftf_pkg::ST_IDLE;
      end
      default: begin
        state_d = mftf_pkg::ST_IDLE;
      end
    endcase

    if (advance) begin
      if (chan_q == 2'd2) begin
        state_d = check_q ? mftf_pkg::ST_DECIDE : mftf_pkg::ST_DONE;
      end else begin
        chan_d  = chan_nx;
        num_d   = sum_q[chan_nx];
        rem_d   = '0;
        step_d  = '0;
        state_d = mftf_pkg::ST_DIV;
      end
    end

    if (start_div) begin
      chan_d  = '0;
      step_d  = '0;
      rem_d   = '0;
      num_d   = sum_d[0];
      state_d = mftf_pkg::ST_DIV;
    end

    ram_wdata = {sum_d[2], sum_d[1], sum_d[0], cnt_d};
    if (state_q == mftf_pkg::ST_CLEAR) begin
      ram_wdata = '0;
    end
  end

  assign busy_o         = state_q != mftf_pkg::ST_IDLE;
  assign done_o         = state_q == mftf_pkg::ST_DONE;
  assign red_avg_o      = out_q[0];
  assign green_avg_o    = out_q[1];
  assign blue_avg_o     = out_q[2];
  assign sample_total_o = cnt_q;
  assign action_o       = act_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted beat did not raise busy");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy_o)
    else $error("store written while idle");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && sample_total_o == '0) |->
      (red_avg_o == '0 && green_avg_o == '0 && blue_avg_o == '0))
    else $error("empty texel reported a nonzero mean");

  a_write_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (action_o == 3'(mftf_pkg::ACT_FIRST) || action_o == 3'(mftf_pkg::ACT_RESTART)))
      |-> (sample_total_o == CNT_W'(1)))
    else $error("fresh texel count is not one");

endmodule

/* rtl/core/mftf_ram.sv */
// Generic single-port RAM with registered read, no reset on contents.
// Standalone; used for the texel store of multi_frame_texel_fusion.
module mftf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

/* verif/tb_multi_frame_texel_fusion.sv */
// Self-checking testbench for multi_frame_texel_fusion: directed rows, then random beats over
// several outlier ratios and sender gap rates, checked against pinned values or a predictor.
// Depends on mftf_pkg and the multi_frame_texel_fusion RTL only.
module tb_multi_frame_texel_fusion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        MODE_FOLD  = 1'b0;
  localparam logic        MODE_READ  = 1'b1;
  localparam logic [15:0] HOT_TEXEL  = 16'hFFFF;
  localparam int          NUM_PHASES = 7;
  localparam int          PHASE_BEATS = 193;
  localparam int          TAIL_CYCLES = 120;
  localparam int          STALL_LIMIT = 200000;

  localparam logic [15:0] POOL [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                       16'h0100, 16'h1234, 16'h8000, 16'hFFFE};
  localparam int unsigned PHASE_RATIO [NUM_PHASES] = '{255, 2, 128, 1, 0, 0, 5};
  localparam int unsigned PHASE_GAP   [NUM_PHASES] = '{0, 51, 20, 0, 51, 20, 0};

  typedef struct packed {
    logic                      mode;
    logic [mftf_pkg::IDX_W-1:0] idx;
    logic [mftf_pkg::CH_W-1:0] red;
    logic [mftf_pkg::CH_W-1:0] green;
    logic [mftf_pkg::CH_W-1:0] blue;
  } texel_req_t;

  typedef struct packed {
    logic [mftf_pkg::CH_W-1:0]  red;
    logic [mftf_pkg::CH_W-1:0]  green;
    logic [mftf_pkg::CH_W-1:0]  blue;
    logic [mftf_pkg::CNT_W-1:0] total;
    mftf_pkg::action_e          act;
  } texel_mean_t;

  typedef struct packed {
    texel_req_t  req;
    logic        pin;
    texel_mean_t want;
  } texel_row_t;

  localparam texel_row_t DIRECTED_ROWS [24] = '{
    '{'{MODE_READ, 16'h0000,   0,   0,   0}, 1'b1, '{  0,   0,   0, 0, mftf_pkg::ACT_READ}},
    '{'{MODE_READ, 16'hFFFF, 255, 255, 255}, 1'b1, '{  0,   0,   0, 0, mftf_pkg::ACT_READ}},
    '{'{MODE_FOLD, 16'h0000,   0, 255, 255}, 1'b1, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'h0001, 255, 255, 255}, 1'b1, '{255, 255, 255, 1, mftf_pkg::ACT_FIRST}},
    '{'{MODE_FOLD, 16'h0001, 255, 255, 255}, 1'b1, '{255, 255, 255, 2, mftf_pkg::ACT_ADD}},
    '{'{MODE_READ, 16'h0001,   0,   0,   0}, 1'b1, '{255, 255, 255, 2, mftf_pkg::ACT_READ}},
    '{'{MODE_FOLD, 16'h0001, 255, 255,   0}, 1'b1, '{255, 255, 255, 2, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'h0002,   1,   1,   1}, 1'b1, '{  1,   1,   1, 1, mftf_pkg::ACT_FIRST}},
    '{'{MODE_FOLD, 16'h0002, 128,  64,  32}, 1'b1, '{128,  64,  32, 1, mftf_pkg::ACT_RESTART}},
    '{'{MODE_FOLD, 16'h0002,   1,   1,   1}, 1'b1, '{128,  64,  32, 1, mftf_pkg::ACT_REJECT}},
    '{'{MODE_FOLD, 16'h0002,   1, 200,   1}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'h0003, 255,   0, 255}, 1'b1, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'hFFFF, 170,  85,   1}, 1'b1, '{170,  85,   1, 1, mftf_pkg::ACT_FIRST}},
    '{'{MODE_FOLD, 16'hFFFF,   1,   1,   1}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'h8000, 128, 128, 128}, 1'b1, '{128, 128, 128, 1, mftf_pkg::ACT_FIRST}},
    '{'{MODE_FOLD, 16'h8000, 127, 129, 255}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'h8000,   3,   3,   3}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_READ, 16'h0002,   0,   0,   0}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'h5555,  85, 170,  85}, 1'b1, '{ 85, 170,  85, 1, mftf_pkg::ACT_FIRST}},
    '{'{MODE_FOLD, 16'hAAAA, 170,  85, 170}, 1'b1, '{170,  85, 170, 1, mftf_pkg::ACT_FIRST}},
    '{'{MODE_FOLD, 16'hAAAA, 255, 255, 255}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_READ, 16'h8000,   0,   0,   0}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_FOLD, 16'h0002, 255, 255, 255}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}},
    '{'{MODE_READ, 16'hFFFF,   0,   0,   0}, 1'b0, '{  0,   0,   0, 0, mftf_pkg::ACT_DARK}}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       mode_i;
  logic [mftf_pkg::IDX_W-1:0] texel_index_i;
  logic [mftf_pkg::CH_W-1:0]  red_in_i;
  logic [mftf_pkg::CH_W-1:0]  green_in_i;
  logic [mftf_pkg::CH_W-1:0]  blue_in_i;
  logic                       cfg_we_i;
  logic [mftf_pkg::CH_W-1:0]  cfg_wdata_i;
  logic                       done_o;
  logic [mftf_pkg::CH_W-1:0]  red_avg_o;
  logic [mftf_pkg::CH_W-1:0]  green_avg_o;
  logic [mftf_pkg::CH_W-1:0]  blue_avg_o;
  logic [mftf_pkg::CNT_W-1:0] sample_total_o;
  logic [2:0]                 action_o;

  logic        pin_en;
  texel_mean_t pin_want;

  logic [mftf_pkg::SUM_W-1:0] tex_sum [mftf_pkg::TEXEL_COUNT][3];
  logic [mftf_pkg::CNT_W-1:0] tex_count [mftf_pkg::TEXEL_COUNT];
  int unsigned      fold_ratio;
  texel_mean_t      pending_means [$];
  int               err_cnt;
  int               beats_in;
  int               stall_cycles;
  int               action_tally [6];

  multi_frame_texel_fusion uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .texel_index_i (texel_index_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .red_avg_o     (red_avg_o),
    .green_avg_o   (green_avg_o),
    .blue_avg_o    (blue_avg_o),
    .sample_total_o(sample_total_o),
    .action_o      (action_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned round_mean(input int unsigned num, input int unsigned den);
    int unsigned quo;
    int unsigned rem;
    if (den == 0) return 0;
    quo = num / den;
    rem = num % den;
    if (2 * rem > den || (2 * rem == den && quo[0])) quo++;
    return quo;
  endfunction

  function automatic texel_mean_t fuse_texel(input texel_req_t q);
    int unsigned       smp [3];
    int unsigned       avg [3];
    int unsigned       cnt;
    int unsigned       m;
    int unsigned       s;
    bit                above;
    bit                below;
    mftf_pkg::action_e act;
    texel_mean_t       res;
    smp = '{q.red, q.green, q.blue};
    if (q.idx >= mftf_pkg::TEXEL_COUNT) begin
      res = '0;
      res.act = q.mode ? mftf_pkg::ACT_READ : mftf_pkg::ACT_DARK;
      return res;
    end
    if (q.mode == MODE_READ) begin
      act = mftf_pkg::ACT_READ;
    end else if (q.red == 0 || q.green == 0 || q.blue == 0) begin
      act = mftf_pkg::ACT_DARK;
    end else if (tex_count[q.idx] == 0) begin
      for (int c = 0; c < 3; c++) tex_sum[q.idx][c] = mftf_pkg::SUM_W'(smp[c]);
      tex_count[q.idx] = 1;
      act = mftf_pkg::ACT_FIRST;
    end else begin
      cnt = tex_count[q.idx];
      above = 1'b1;
      below = 1'b1;
      for (int c = 0; c < 3; c++) begin
        m = round_mean(tex_sum[q.idx][c], cnt);
        if (!(m > fold_ratio * smp[c])) above = 1'b0;
        if (!(fold_ratio * m < smp[c])) below = 1'b0;
      end
      if (above) begin
        act = mftf_pkg::ACT_REJECT;
      end else if (below) begin
        for (int c = 0; c < 3; c++) tex_sum[q.idx][c] = mftf_pkg::SUM_W'(smp[c]);
        tex_count[q.idx] = 1;
        act = mftf_pkg::ACT_RESTART;
      end else begin
        for (int c = 0; c < 3; c++) begin
          s = tex_sum[q.idx][c] + smp[c];
          tex_sum[q.idx][c] = (s > 65535) ? 16'hFFFF : mftf_pkg::SUM_W'(s);
        end
        if (cnt < mftf_pkg::CNT_MAX) tex_count[q.idx] = mftf_pkg::CNT_W'(cnt + 1);
        act = mftf_pkg::ACT_ADD;
      end
    end
    cnt = tex_count[q.idx];
    for (int c = 0; c < 3; c++) begin
      m = round_mean(tex_sum[q.idx][c], cnt);
      avg[c] = (m > 255) ? 255 : m;
    end
    res = '{mftf_pkg::CH_W'(avg[0]), mftf_pkg::CH_W'(avg[1]), mftf_pkg::CH_W'(avg[2]),
            mftf_pkg::CNT_W'(cnt), act};
    return res;
  endfunction

  always @(posedge clk_i) begin
    texel_mean_t seen;
    texel_mean_t want;
    texel_mean_t pred;
    if (rst_ni && done_o) begin
      seen = '{red_avg_o, green_avg_o, blue_avg_o, sample_total_o,
               mftf_pkg::action_e'(action_o)};
      if (pending_means.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with nothing expected: r=%0d g=%0d b=%0d n=%0d act=%0d",
                 $time, seen.red, seen.green, seen.blue, seen.total, action_o);
      end else begin
        want = pending_means.pop_front();
        action_tally[int'(want.act)]++;
        if (seen !== want) begin
          err_cnt++;
          $display("%0t: mismatch expected r=%0d g=%0d b=%0d n=%0d act=%0d,",
                   $time, want.red, want.green, want.blue, want.total, want.act,
                   " got r=%0d g=%0d b=%0d n=%0d act=%0d",
                   seen.red, seen.green, seen.blue, seen.total, action_o);
        end
      end
    end
    if (rst_ni && cfg_we_i) fold_ratio = cfg_wdata_i;
    if (rst_ni && start_i && !busy_o) begin
      pred = fuse_texel(texel_req_t'{mode_i, texel_index_i, red_in_i, green_in_i,
                                     blue_in_i});
      pending_means.insert(pending_means.size(), pin_en ? pin_want : pred);
      beats_in++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_multi_frame_texel_fusion failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input texel_req_t req, input logic pin, input texel_mean_t want);
    start_i       <= 1'b1;
    mode_i        <= req.mode;
    texel_index_i <= req.idx;
    red_in_i      <= req.red;
    green_in_i    <= req.green;
    blue_in_i     <= req.blue;
    pin_en        <= pin;
    pin_want      <= want;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (busy_o || pending_means.size() != 0);
  endtask

  initial begin
    texel_req_t  req;
    int unsigned sel;
    int unsigned ratio;
    bit          bright;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    mode_i        = MODE_FOLD;
    texel_index_i = '0;
    red_in_i      = '0;
    green_in_i    = '0;
    blue_in_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    pin_en        = 1'b0;
    pin_want      = '0;
    err_cnt       = 0;
    beats_in      = 0;
    stall_cycles  = 0;
    fold_ratio    = mftf_pkg::RATIO_RESET;
    for (int t = 0; t < mftf_pkg::TEXEL_COUNT; t++) begin
      tex_sum[t] = '{3{16'h0000}};
      tex_count[t] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].pin, DIRECTED_ROWS[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      ratio = (ph == 5) ? $urandom_range(3, 254) : PHASE_RATIO[ph];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= mftf_pkg::CH_W'(ratio);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        sel = $urandom_range(99);
        bright = 1'($urandom_range(1));
        req.mode  = MODE_FOLD;
        req.idx   = POOL[3'($urandom_range(7))];
        req.red   = mftf_pkg::CH_W'($urandom_range(255));
        req.green = mftf_pkg::CH_W'($urandom_range(255));
        req.blue  = mftf_pkg::CH_W'($urandom_range(255));
        if (sel < 50) begin
          req.idx   = HOT_TEXEL;
          req.red   = mftf_pkg::CH_W'($urandom_range(224, 255));
          req.green = mftf_pkg::CH_W'($urandom_range(224, 255));
          req.blue  = mftf_pkg::CH_W'($urandom_range(224, 255));
        end else if (sel < 70) begin
          req.red   = mftf_pkg::CH_W'(bright ? $urandom_range(180, 255) : $urandom_range(1, 40));
          req.green = mftf_pkg::CH_W'(bright ? $urandom_range(180, 255) : $urandom_range(1, 40));
          req.blue  = mftf_pkg::CH_W'(bright ? $urandom_range(180, 255) : $urandom_range(1, 40));
        end else if (sel < 80) begin
          case ($urandom_range(2))
            0: req.red = '0;
            1: req.green = '0;
            default: req.blue = '0;
          endcase
        end else if (sel < 92) begin
          req.mode = MODE_READ;
          if (bright) req.idx = HOT_TEXEL;
        end else begin
          req.mode = 1'($urandom_range(1));
          req.idx  = mftf_pkg::IDX_W'($urandom_range(16'hFFFF));
        end
        send_beat(req, 1'b0, '0);
        if (PHASE_GAP[ph] != 0 && $urandom_range(99) < PHASE_GAP[ph]) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 130)) @(posedge clk_i);
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_means.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected result beats never arrived", $time, pending_means.size());
    end
    $display("covered %0d request beats: directed corners, then %0d outlier ratio settings",
             beats_in, NUM_PHASES);
    $display("actions: dark %0d first %0d rejected %0d restarted %0d added %0d read %0d",
             action_tally[0], action_tally[1], action_tally[2], action_tally[3],
             action_tally[4], action_tally[5]);
    if (err_cnt == 0) begin
      $display("tb_multi_frame_texel_fusion passed");
    end else begin
      $display("tb_multi_frame_texel_fusion failed");
    end
    $finish;
  end

endmodule

/* multi_frame_texel_fusion.f */
rtl/core/mftf_pkg.sv
rtl/core/mftf_ram.sv
rtl/core/multi_frame_texel_fusion.sv
verif/tb_multi_frame_texel_fusion.sv
